// File: hdl/grec_pkg.sv
package grec_pkg;

  localparam int unsigned MAX_NODE_COUNT = 64;
  localparam int unsigned IdxW = (MAX_NODE_COUNT > 1) ? $clog2(MAX_NODE_COUNT) : 1;
  localparam int unsigned CntW = $clog2(MAX_NODE_COUNT + 1);
  localparam int unsigned IdW = 16;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [IdW-1:0] id_t;
  typedef logic [MAX_NODE_COUNT-1:0] row_t;

  typedef enum logic [1:0] {
    KIND_INSERT_NODE,
    KIND_INSERT_EDGE,
    KIND_QUERY_EDGE,
    KIND_QUERY_REACH
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_FULL,
    STATUS_DUP,
    STATUS_UNKNOWN
  } status_e;

  typedef enum logic [1:0] {
    OP_CLEAR_ROW,
    OP_SET_EDGE,
    OP_TEST_EDGE,
    OP_REACH
  } walk_op_e;

  typedef struct packed {
    kind_e kind;
    id_t   first_id;
    id_t   second_id;
  } in_item_t;

  typedef struct packed {
    status_e status;
    logic    answer;
  } out_item_t;

  typedef struct packed {
    logic     start;
    walk_op_e op;
    idx_t     src;
    idx_t     dst;
  } walk_cmd_t;

  typedef struct packed {
    logic done;
    logic answer;
  } walk_rsp_t;

  typedef struct packed {
    logic done;
    logic found_a;
    logic found_b;
    idx_t idx_a;
    idx_t idx_b;
  } search_rsp_t;

  // index of the lowest set bit
  function automatic idx_t first_set_idx(row_t v);
    row_t low;
    idx_t idx;
    low = v & (~v + row_t'(1));
    idx = '0;
    for (int b = 0; b < IdxW; b++) begin
      for (int i = 0; i < MAX_NODE_COUNT; i++) begin
        if (i[b]) begin
          idx[b] = idx[b] | low[i];
        end
      end
    end
    return idx;
  endfunction

endpackage

// File: hdl/grec_id_search.sv
module grec_id_search (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  grec_pkg::id_t         id_a_i,
  input  grec_pkg::id_t         id_b_i,
  input  grec_pkg::cnt_t        count_i,
  input  logic                  wr_en_i,
  input  grec_pkg::idx_t        wr_idx_i,
  input  grec_pkg::id_t         wr_id_i,
  output grec_pkg::search_rsp_t rsp_o
);

  grec_pkg::id_t  mem_q [grec_pkg::MAX_NODE_COUNT];
  grec_pkg::id_t  rd_data_q;
  grec_pkg::cnt_t addr_q;
  grec_pkg::idx_t rd_idx_q;
  grec_pkg::idx_t idx_a_q;
  grec_pkg::idx_t idx_b_q;
  logic           running_q;
  logic           rd_valid_q;
  logic           found_a_q;
  logic           found_b_q;
  logic           done_q;
  logic           rd_en;

  assign rd_en = running_q && (addr_q < count_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_id_i;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[addr_q[grec_pkg::IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q  <= 1'b0;
      rd_valid_q <= 1'b0;
      addr_q     <= '0;
      rd_idx_q   <= '0;
      found_a_q  <= 1'b0;
      found_b_q  <= 1'b0;
      idx_a_q    <= '0;
      idx_b_q    <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        running_q  <= 1'b1;
        rd_valid_q <= 1'b0;
        addr_q     <= '0;
        found_a_q  <= 1'b0;
        found_b_q  <= 1'b0;
      end else if (running_q) begin
        rd_valid_q <= rd_en;
        rd_idx_q   <= addr_q[grec_pkg::IdxW-1:0];
        if (rd_en) begin
          addr_q <= addr_q + grec_pkg::cnt_t'(1);
        end
        if (rd_valid_q) begin
          if (!found_a_q && (rd_data_q == id_a_i)) begin
            found_a_q <= 1'b1;
            idx_a_q   <= rd_idx_q;
          end
          if (!found_b_q && (rd_data_q == id_b_i)) begin
            found_b_q <= 1'b1;
            idx_b_q   <= rd_idx_q;
          end
        end
        if (!rd_en && !rd_valid_q) begin
          running_q <= 1'b0;
          done_q    <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.found_a = found_a_q;
  assign rsp_o.found_b = found_b_q;
  assign rsp_o.idx_a   = idx_a_q;
  assign rsp_o.idx_b   = idx_b_q;

endmodule

// File: hdl/grec_walk.sv
module grec_walk (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  grec_pkg::walk_cmd_t cmd_i,
  output grec_pkg::walk_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    W_IDLE,
    W_RMW,
    W_POP,
    W_FETCH,
    W_ROW,
    W_PUSH
  } state_e;

  state_e             state_q;
  grec_pkg::walk_op_e op_q;
  grec_pkg::idx_t     src_q;
  grec_pkg::idx_t     dst_q;
  grec_pkg::row_t     visited_q;
  grec_pkg::row_t     pend_q;
  grec_pkg::cnt_t     depth_q;
  logic               done_q;
  logic               answer_q;

  grec_pkg::row_t     adj_q [grec_pkg::MAX_NODE_COUNT];
  grec_pkg::idx_t     stack_q [grec_pkg::MAX_NODE_COUNT];
  grec_pkg::row_t     adj_rd_q;
  grec_pkg::idx_t     stk_rd_q;

  logic               adj_we;
  logic               adj_re;
  grec_pkg::idx_t     adj_waddr;
  grec_pkg::idx_t     adj_raddr;
  grec_pkg::row_t     adj_wdata;
  logic               stk_we;
  logic               stk_re;
  grec_pkg::idx_t     stk_waddr;
  grec_pkg::idx_t     stk_raddr;
  grec_pkg::idx_t     stk_wdata;
  grec_pkg::cnt_t     depth_m1;
  grec_pkg::row_t     dst_mask;
  grec_pkg::idx_t     push_idx;
  grec_pkg::row_t     push_low;

  assign depth_m1 = depth_q - grec_pkg::cnt_t'(1);
  assign dst_mask = grec_pkg::row_t'(1) << dst_q;
  assign push_idx = grec_pkg::first_set_idx(pend_q);
  assign push_low = grec_pkg::row_t'(1) << push_idx;

  always_comb begin
    adj_we    = 1'b0;
    adj_re    = 1'b0;
    adj_waddr = '0;
    adj_raddr = '0;
    adj_wdata = '0;
    stk_we    = 1'b0;
    stk_re    = 1'b0;
    stk_waddr = '0;
    stk_raddr = '0;
    stk_wdata = '0;
    unique case (state_q)
      W_IDLE: begin
        if (cmd_i.start) begin
          unique case (cmd_i.op)
            grec_pkg::OP_CLEAR_ROW: begin
              adj_we    = 1'b1;
              adj_waddr = cmd_i.src;
            end
            grec_pkg::OP_SET_EDGE, grec_pkg::OP_TEST_EDGE: begin
              adj_re    = 1'b1;
              adj_raddr = cmd_i.src;
            end
            grec_pkg::OP_REACH: begin
              stk_we    = 1'b1;
              stk_wdata = cmd_i.src;
            end
            default: begin
            end
          endcase
        end
      end
      W_RMW: begin
        if (op_q == grec_pkg::OP_SET_EDGE) begin
          adj_we    = 1'b1;
          adj_waddr = src_q;
          adj_wdata = adj_rd_q | dst_mask;
        end
      end
      W_POP: begin
        if (depth_q != '0) begin
          stk_re    = 1'b1;
          stk_raddr = depth_m1[grec_pkg::IdxW-1:0];
        end
      end
      W_FETCH: begin
        adj_re    = 1'b1;
        adj_raddr = stk_rd_q;
      end
      W_ROW: begin
      end
      W_PUSH: begin
        if (pend_q != '0) begin
          stk_we    = 1'b1;
          stk_waddr = depth_q[grec_pkg::IdxW-1:0];
          stk_wdata = push_idx;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_q[adj_waddr] <= adj_wdata;
    end
    if (adj_re) begin
      adj_rd_q <= adj_q[adj_raddr];
    end
    if (stk_we) begin
      stack_q[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rd_q <= stack_q[stk_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= W_IDLE;
      op_q      <= grec_pkg::OP_CLEAR_ROW;
      src_q     <= '0;
      dst_q     <= '0;
      visited_q <= '0;
      pend_q    <= '0;
      depth_q   <= '0;
      done_q    <= 1'b0;
      answer_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        W_IDLE: begin
          if (cmd_i.start) begin
            op_q  <= cmd_i.op;
            src_q <= cmd_i.src;
            dst_q <= cmd_i.dst;
            unique case (cmd_i.op)
              grec_pkg::OP_CLEAR_ROW: begin
                done_q   <= 1'b1;
                answer_q <= 1'b0;
              end
              grec_pkg::OP_SET_EDGE, grec_pkg::OP_TEST_EDGE: begin
                state_q <= W_RMW;
              end
              grec_pkg::OP_REACH: begin
                visited_q <= grec_pkg::row_t'(1) << cmd_i.src;
                depth_q   <= grec_pkg::cnt_t'(1);
                state_q   <= W_POP;
              end
              default: begin
              end
            endcase
          end
        end
        W_RMW: begin
          done_q   <= 1'b1;
          answer_q <= (op_q == grec_pkg::OP_TEST_EDGE) && adj_rd_q[dst_q];
          state_q  <= W_IDLE;
        end
        W_POP: begin
          if (depth_q == '0) begin
            done_q   <= 1'b1;
            answer_q <= 1'b0;
            state_q  <= W_IDLE;
          end else begin
            depth_q <= depth_m1;
            state_q <= W_FETCH;
          end
        end
        W_FETCH: begin
          state_q <= W_ROW;
        end
        W_ROW: begin
          if (adj_rd_q[dst_q]) begin
            done_q   <= 1'b1;
            answer_q <= 1'b1;
            state_q  <= W_IDLE;
          end else begin
            pend_q    <= adj_rd_q & ~visited_q;
            visited_q <= visited_q | adj_rd_q;
            state_q   <= W_PUSH;
          end
        end
        W_PUSH: begin
          if (pend_q == '0) begin
            state_q <= W_POP;
          end else begin
            pend_q  <= pend_q & ~push_low;
            depth_q <= depth_q + grec_pkg::cnt_t'(1);
          end
        end
        default: begin
          state_q <= W_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.answer = answer_q;

endmodule

// File: hdl/graph_reachability_engine_unit.sv
// Directed graph store of up to MAX_NODE_COUNT nodes with 16-bit IDs, taking one item at a time
// (node insert, edge insert, direct edge query, reachability query) and returning one result
// item for each. Every item first scans the ID table at one entry per cycle before any graph
// work. A node insert with a new ID and room in the table then clears the new node's adjacency
// row, edge inserts and edge queries read the source row (an insert writes it back with the new
// edge), and the result register is loaded once the output is free. A reachability walk pops
// a node from the stack, reads its adjacency row through the single read port of the adjacency
// memory, then pushes each newly reached node onto the stack in turn. A finished result sits
// in the output register while the next item is already accepted.
module graph_reachability_engine_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  grec_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output grec_pkg::out_item_t out_item_o
);

  typedef enum logic [1:0] {
    T_IDLE,
    T_SEARCH,
    T_EXEC,
    T_RESP
  } state_e;

  state_e                state_q;
  grec_pkg::in_item_t    item_q;
  grec_pkg::cnt_t        count_q;
  grec_pkg::status_e     status_q;
  logic                  answer_q;
  logic                  out_valid_q;
  grec_pkg::out_item_t   out_item_q;

  logic                  in_accept;
  logic                  out_load;
  logic                  is_node;
  logic                  table_full;
  logic                  node_ok;
  logic                  ids_known;
  logic                  id_wr_en;
  grec_pkg::search_rsp_t srch_rsp;
  grec_pkg::walk_cmd_t   walk_cmd;
  grec_pkg::walk_rsp_t   walk_rsp;
  grec_pkg::walk_op_e    walk_op;

  assign in_stall_o  = (state_q != T_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == T_RESP) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign is_node    = (item_q.kind == grec_pkg::KIND_INSERT_NODE);
  assign table_full = (count_q == grec_pkg::cnt_t'(grec_pkg::MAX_NODE_COUNT));
  assign node_ok    = !table_full && !srch_rsp.found_a;
  assign ids_known  = srch_rsp.found_a && srch_rsp.found_b;
  assign id_wr_en   = (state_q == T_SEARCH) && srch_rsp.done && is_node && node_ok;

  always_comb begin
    unique case (item_q.kind)
      grec_pkg::KIND_INSERT_NODE: walk_op = grec_pkg::OP_CLEAR_ROW;
      grec_pkg::KIND_INSERT_EDGE: walk_op = grec_pkg::OP_SET_EDGE;
      grec_pkg::KIND_QUERY_EDGE:  walk_op = grec_pkg::OP_TEST_EDGE;
      grec_pkg::KIND_QUERY_REACH: walk_op = grec_pkg::OP_REACH;
      default:                    walk_op = grec_pkg::OP_CLEAR_ROW;
    endcase
  end

  always_comb begin
    walk_cmd.start = (state_q == T_SEARCH) && srch_rsp.done && (is_node ? node_ok : ids_known);
    walk_cmd.op    = walk_op;
    walk_cmd.src   = is_node ? count_q[grec_pkg::IdxW-1:0] : srch_rsp.idx_a;
    walk_cmd.dst   = srch_rsp.idx_b;
  end

  grec_id_search u_id_search (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_accept),
    .id_a_i   (item_q.first_id),
    .id_b_i   (item_q.second_id),
    .count_i  (count_q),
    .wr_en_i  (id_wr_en),
    .wr_idx_i (count_q[grec_pkg::IdxW-1:0]),
    .wr_id_i  (item_q.first_id),
    .rsp_o    (srch_rsp)
  );

  grec_walk u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (walk_cmd),
    .rsp_o  (walk_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      item_q      <= '0;
      count_q     <= '0;
      status_q    <= grec_pkg::STATUS_OK;
      answer_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        T_IDLE: begin
          if (in_accept) begin
            item_q   <= in_item_i;
            status_q <= grec_pkg::STATUS_OK;
            answer_q <= 1'b0;
            state_q  <= T_SEARCH;
          end
        end
        T_SEARCH: begin
          if (srch_rsp.done) begin
            if (is_node) begin
              if (table_full) begin
                status_q <= grec_pkg::STATUS_FULL;
                state_q  <= T_RESP;
              end else if (srch_rsp.found_a) begin
                status_q <= grec_pkg::STATUS_DUP;
                state_q  <= T_RESP;
              end else begin
                count_q <= count_q + grec_pkg::cnt_t'(1);
                state_q <= T_EXEC;
              end
            end else if (!ids_known) begin
              status_q <= grec_pkg::STATUS_UNKNOWN;
              state_q  <= T_RESP;
            end else begin
              state_q <= T_EXEC;
            end
          end
        end
        T_EXEC: begin
          if (walk_rsp.done) begin
            answer_q <= walk_rsp.answer;
            state_q  <= T_RESP;
          end
        end
        T_RESP: begin
          if (out_load) begin
            out_item_q.status <= status_q;
            out_item_q.answer <= answer_q;
            state_q           <= T_IDLE;
          end
        end
        default: begin
          state_q <= T_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= grec_pkg::cnt_t'(grec_pkg::MAX_NODE_COUNT))
    else $error("node count beyond table size");

  a_walk_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_cmd.start |-> (state_q == T_SEARCH) && srch_rsp.done)
    else $error("walk started outside search completion");

  a_search_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    srch_rsp.done |-> state_q == T_SEARCH)
    else $error("id search finished while not searching");

  a_walk_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_rsp.done |-> state_q == T_EXEC)
    else $error("walk finished while not executing");
`endif

endmodule

// File: sim/tb_graph_reachability_engine_unit.sv
module tb_graph_reachability_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import grec_pkg::*;

  localparam int unsigned LONG_HOLD = 600;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 400;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  graph_reachability_engine_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // graph mirror
  id_t         node_tab [MAX_NODE_COUNT];
  int unsigned node_cnt = 0;
  row_t        adj_rows [MAX_NODE_COUNT];

  out_item_t result_q [$];
  int unsigned fail_count = 0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;

  function automatic int find_node(id_t id);
    for (int i = 0; i < node_cnt; i++) begin
      if (node_tab[i] == id) begin
        return i;
      end
    end
    return -1;
  endfunction

  // depth-first walk, found when dst is a successor of a reached node
  function automatic bit walk_reaches(int src, int dst);
    row_t seen;
    int   stack [$];
    int   u;
    seen = '0;
    seen[src] = 1'b1;
    stack.push_back(src);
    while (stack.size() > 0) begin
      u = stack.pop_back();
      for (int i = 0; i < node_cnt; i++) begin
        if (adj_rows[u][i]) begin
          if (i == dst) begin
            return 1'b1;
          end
          if (!seen[i]) begin
            seen[i] = 1'b1;
            stack.push_back(i);
          end
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic out_item_t apply_item(in_item_t it);
    out_item_t res;
    int ia;
    int ib;
    res.status = STATUS_OK;
    res.answer = 1'b0;
    if (it.kind == KIND_INSERT_NODE) begin
      if (node_cnt >= MAX_NODE_COUNT) begin
        res.status = STATUS_FULL;
      end else if (find_node(it.first_id) >= 0) begin
        res.status = STATUS_DUP;
      end else begin
        node_tab[node_cnt] = it.first_id;
        adj_rows[node_cnt] = '0;
        for (int r = 0; r < MAX_NODE_COUNT; r++) begin
          adj_rows[r][node_cnt] = 1'b0;
        end
        node_cnt++;
      end
    end else begin
      ia = find_node(it.first_id);
      ib = find_node(it.second_id);
      if (ia < 0 || ib < 0) begin
        res.status = STATUS_UNKNOWN;
      end else if (it.kind == KIND_INSERT_EDGE) begin
        adj_rows[ia][ib] = 1'b1;
      end else if (it.kind == KIND_QUERY_EDGE) begin
        res.answer = adj_rows[ia][ib];
      end else begin
        res.answer = walk_reaches(ia, ib);
      end
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic id_t pick_id();
    if (node_cnt > 0 && $urandom_range(0, 9) != 0) begin
      return node_tab[$urandom_range(0, node_cnt - 1)];
    end
    return id_t'($urandom);
  endfunction

  function automatic id_t fresh_id();
    id_t id;
    id = id_t'($urandom);
    while (find_node(id) >= 0) begin
      id = id_t'($urandom);
    end
    return id;
  endfunction

  task automatic send_item(input kind_e kind, input id_t a, input id_t b);
    int gap;
    in_item_t it;
    it.kind = kind;
    it.first_id = a;
    it.second_id = b;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    result_q.push_back(apply_item(it));
  endtask

  task automatic test_directed_cases();
    send_item(KIND_INSERT_NODE, 16'h0000, 16'hFFFF);
    send_item(KIND_INSERT_NODE, 16'hFFFF, 16'h0000);
    send_item(KIND_INSERT_NODE, 16'hFFFF, 16'h1234);
    send_item(KIND_INSERT_NODE, 16'h5A5A, 16'hFFFF);
    send_item(KIND_INSERT_EDGE, 16'h0000, 16'hA5A5);
    send_item(KIND_INSERT_EDGE, 16'hA5A5, 16'h0000);
    send_item(KIND_QUERY_EDGE, 16'h0000, 16'h7777);
    send_item(KIND_QUERY_REACH, 16'h8888, 16'hFFFF);
    send_item(KIND_INSERT_EDGE, 16'h0000, 16'hFFFF);
    send_item(KIND_INSERT_EDGE, 16'h0000, 16'hFFFF);
    send_item(KIND_INSERT_EDGE, 16'hFFFF, 16'h5A5A);
    send_item(KIND_QUERY_EDGE, 16'h0000, 16'hFFFF);
    send_item(KIND_QUERY_EDGE, 16'hFFFF, 16'h0000);
    send_item(KIND_QUERY_REACH, 16'h0000, 16'h5A5A);
    send_item(KIND_QUERY_REACH, 16'h5A5A, 16'h0000);
    // self reach without a cycle, then with one
    send_item(KIND_QUERY_REACH, 16'h0000, 16'h0000);
    send_item(KIND_INSERT_EDGE, 16'h5A5A, 16'h0000);
    send_item(KIND_QUERY_REACH, 16'h0000, 16'h0000);
    send_item(KIND_QUERY_EDGE, 16'h5A5A, 16'h5A5A);
    send_item(KIND_INSERT_EDGE, 16'h5A5A, 16'h5A5A);
    send_item(KIND_QUERY_EDGE, 16'h5A5A, 16'h5A5A);
    send_item(KIND_QUERY_REACH, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_random_traffic(input int n_items);
    int r;
    int node_pct;
    int ia;
    int ib;
    int t;
    id_t a;
    id_t b;
    for (int k = 0; k < n_items; k++) begin
      if (k % 100 == 0) begin
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      node_pct = (node_cnt < MAX_NODE_COUNT) ? 25 : 5;
      r = $urandom_range(0, 99);
      a = pick_id();
      b = pick_id();
      if (r < node_pct) begin
        if ($urandom_range(0, 9) != 0) begin
          a = id_t'($urandom);
        end
        send_item(KIND_INSERT_NODE, a, b);
      end else if (r < node_pct + 25) begin
        if (node_cnt > 0 && $urandom_range(0, 9) != 0) begin
          ia = $urandom_range(0, node_cnt - 1);
          ib = $urandom_range(0, node_cnt - 1);
          // mostly forward edges so that some walks fail
          if (ia > ib && $urandom_range(0, 19) != 0) begin
            t = ia;
            ia = ib;
            ib = t;
          end
          a = node_tab[ia];
          b = node_tab[ib];
        end
        send_item(KIND_INSERT_EDGE, a, b);
      end else if (r < node_pct + 45) begin
        send_item(KIND_QUERY_EDGE, a, b);
      end else begin
        send_item(KIND_QUERY_REACH, a, b);
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_full_table();
    id_t known;
    while (node_cnt < MAX_NODE_COUNT) begin
      send_item(KIND_INSERT_NODE, fresh_id(), 16'h0000);
    end
    known = node_tab[0];
    send_item(KIND_INSERT_NODE, fresh_id(), 16'hFFFF);
    send_item(KIND_INSERT_NODE, known, 16'h0000);
    send_item(KIND_QUERY_REACH, node_tab[MAX_NODE_COUNT - 1], node_tab[0]);
    send_item(KIND_QUERY_REACH, node_tab[0], node_tab[MAX_NODE_COUNT - 1]);
  endtask

  task automatic test_stall_pressure();
    hold_req = 1'b1;
    no_gaps = 1'b1;
    for (int k = 0; k < 16; k++) begin
      send_item(KIND_QUERY_REACH, pick_id(), pick_id());
    end
    no_gaps = 1'b0;
  endtask

  // receiver
  initial begin : result_sink
    int s;
    int r;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        s = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        s = no_gaps ? 0 : pick_gap();
      end
      r = no_gaps ? 8 : $urandom_range(1, 12);
      if (s > 0) begin
        out_stall_i <= 1'b1;
        repeat (s) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat (r) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        $error("unexpected result: status %0d answer %0d",
               out_item_o.status, out_item_o.answer);
        fail_count++;
      end else begin
        want = result_q.pop_front();
        if (out_item_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item_o.status);
          fail_count++;
        end
        if (out_item_o.answer !== want.answer) begin
          $error("answer: expected %0d, got %0d", want.answer, out_item_o.answer);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted item or delivered result
  always @(posedge clk_i) begin : watchdog
    int unsigned idle_cycles;
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_traffic(700);
    test_full_table();
    test_stall_pressure();
    in_valid_i <= 1'b0;
    wait (result_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
